// File: rtl/calendar_alarm_table_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// calendar alarm table matcher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CALENDAR_ALARM_TABLE_MATCHER_TOP_DEFINES_SVH
`define CALENDAR_ALARM_TABLE_MATCHER_TOP_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define CATM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar alarm matcher check failed");

// consequent checked in the same cycle as the antecedent
`define CATM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar alarm matcher check failed");

`endif

// File: rtl/catm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catm_pkg
// types and constants shared by the calendar alarm matcher cells and top level
// ----------------------------------------------------------------------------
package catm_pkg;

  localparam int unsigned EntryCountDef = 8;
  localparam int unsigned MaxFires      = 8;
  localparam int unsigned FireCntW      = $clog2(MaxFires + 1);

  // a pattern field at or above its limit matches anything
  localparam logic [5:0] MinuteWild    = 6'd60;
  localparam logic [4:0] HourWild      = 5'd24;
  localparam logic [2:0] WeekdayWild   = 3'd7;
  localparam logic [4:0] DayWild       = 5'd31;
  localparam logic [3:0] MonthWild     = 4'd12;
  localparam logic [7:0] RepeatForever = 8'd255;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [4:0] month_length;
  } tick_t;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] tag;
  } pattern_t;

  // scan token handed from cell to cell, with the firings counted so far
  typedef struct packed {
    logic                tok;
    logic [FireCntW-1:0] cnt;
  } link_t;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StFlush = 3'b100
  } state_e;

endpackage

// File: rtl/catm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catm_cell
// one alarm entry: pattern, repeat count, enable and the passing scan token
// ----------------------------------------------------------------------------
module catm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               wr_i,
  input  catm_pkg::pattern_t wr_pat_i,
  input  logic               wr_en_i,
  input  logic [7:0]         wr_rep_i,
  input  catm_pkg::tick_t    tick_i,
  input  catm_pkg::link_t    link_i,
  output catm_pkg::link_t    link_o,
  output logic               hit_o,
  output logic [7:0]         tag_o
);

  catm_pkg::pattern_t                pat_q;
  logic [7:0]                        rep_q, rep_d;
  logic                              active_q, active_d;
  logic                              tok_q;
  logic [catm_pkg::FireCntW-1:0]     cnt_q;

  logic [4:0] last_day, day_clamp, win_lo, win_hi;
  logic [5:0] day_plus3;
  logic       m_min, m_hour, m_wday, m_day, m_month, match;

  always_comb begin
    last_day  = (tick_i.month_length == 5'd0) ? 5'd0 : tick_i.month_length - 5'd1;
    day_clamp = (pat_q.day < last_day) ? pat_q.day : last_day;
    day_plus3 = {1'b0, day_clamp} + 6'd3;
    // window of up to seven days around the clamped pattern day
    if (day_clamp <= 5'd3) begin
      win_lo = 5'd0;
      win_hi = 5'd6;
    end else if (day_plus3 >= {1'b0, last_day}) begin
      win_lo = (last_day >= 5'd6) ? last_day - 5'd6 : 5'd0;
      win_hi = last_day;
    end else begin
      win_lo = day_clamp - 5'd3;
      win_hi = day_clamp + 5'd3;
    end

    m_min   = (pat_q.minute >= catm_pkg::MinuteWild) || (pat_q.minute == tick_i.minute);
    m_hour  = (pat_q.hour >= catm_pkg::HourWild) || (pat_q.hour == tick_i.hour);
    m_wday  = (pat_q.weekday >= catm_pkg::WeekdayWild) || (pat_q.weekday == tick_i.weekday);
    m_month = (pat_q.month >= catm_pkg::MonthWild) || (pat_q.month == tick_i.month);
    if (pat_q.day >= catm_pkg::DayWild) begin
      m_day = 1'b1;
    end else if (pat_q.weekday < catm_pkg::WeekdayWild) begin
      m_day = (tick_i.day >= win_lo) && (tick_i.day <= win_hi);
    end else begin
      m_day = (day_clamp == tick_i.day);
    end
    match = m_min && m_hour && m_wday && m_day && m_month;
  end

  assign hit_o       = tok_q && active_q && match &&
                       (cnt_q < catm_pkg::FireCntW'(catm_pkg::MaxFires));
  assign tag_o       = pat_q.tag;
  assign link_o.tok  = tok_q;
  assign link_o.cnt  = cnt_q + catm_pkg::FireCntW'(hit_o);

  always_comb begin
    active_d = active_q;
    rep_d    = rep_q;
    if (wr_i) begin
      active_d = wr_en_i;
      rep_d    = wr_rep_i;
    end else if (hit_o && adv_i) begin
      if (rep_q == 8'd0) begin
        active_d = 1'b0;
      end else if (rep_q != catm_pkg::RepeatForever) begin
        rep_d = rep_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (adv_i) begin
        tok_q <= link_i.tok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
    if (adv_i) begin
      cnt_q <= link_i.cnt;
    end
    if (wr_i) begin
      pat_q <= wr_pat_i;
    end
  end

endmodule

// File: rtl/calendar_alarm_table_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_alarm_table_matcher_top
// alarm table matcher built as a row of entry cells walked by a scan token
// ----------------------------------------------------------------------------
// A write item loads one entry. A tick item sends a token down the row of
// ENTRY_COUNT cells, one cell per cycle while the row is not frozen, and
// each matching enabled entry reports its index and tag in index order; the
// last report of a tick carries last_fired. A tick keeps the input stalled
// through its scan and flush, and longer while the output side stalls a
// waiting report, since one result is held back until the next is known.
// ----------------------------------------------------------------------------
module calendar_alarm_table_matcher_top #(
  parameter int unsigned ENTRY_COUNT = catm_pkg::EntryCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [2:0] entry_index_i,
  input  logic [5:0] minute_i,
  input  logic [4:0] hour_i,
  input  logic [2:0] weekday_i,
  input  logic [4:0] day_of_month_i,
  input  logic [3:0] month_number_i,
  input  logic [4:0] month_length_i,
  input  logic       entry_enable_i,
  input  logic [7:0] repeat_count_i,
  input  logic [7:0] entry_tag_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] fired_index_o,
  output logic [7:0] fired_tag_o,
  output logic       last_fired_o
);

  catm_pkg::state_e   state_q, state_d;
  catm_pkg::tick_t    tick_q;
  catm_pkg::pattern_t wr_pat;
  catm_pkg::link_t    link [ENTRY_COUNT+1];

  logic [ENTRY_COUNT-1:0] hit;
  logic [7:0]             tag [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] wr_sel;

  logic       in_xfer, tick_xfer, wr_xfer;
  logic       hit_any, scan_end, adv, out_free;
  logic [2:0] hit_idx;
  logic [7:0] hit_tag;
  logic       pend_valid_q, pend_valid_d;
  logic [2:0] pend_idx_q;
  logic [7:0] pend_tag_q;
  logic       out_valid_q, out_valid_d;
  logic       push_scan, push_flush;
  logic [2:0] out_idx_q;
  logic [7:0] out_tag_q;
  logic       out_last_q;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign tick_xfer = in_xfer && !kind_i;
  assign wr_xfer   = in_xfer && kind_i;

  assign wr_pat = '{minute:  minute_i,
                    hour:    hour_i,
                    weekday: weekday_i,
                    day:     day_of_month_i,
                    month:   month_number_i,
                    tag:     entry_tag_i};

  assign link[0] = '{tok: tick_xfer, cnt: '0};

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    assign wr_sel[g] = wr_xfer && (32'(entry_index_i) == g);
    catm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .wr_i     (wr_sel[g]),
      .wr_pat_i (wr_pat),
      .wr_en_i  (entry_enable_i),
      .wr_rep_i (repeat_count_i),
      .tick_i   (tick_q),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .hit_o    (hit[g]),
      .tag_o    (tag[g])
    );
  end

  // only the cell holding the token can hit
  always_comb begin
    hit_idx = '0;
    hit_tag = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | 3'(i);
        hit_tag = hit_tag | tag[i];
      end
    end
  end

  assign hit_any  = |hit;
  assign scan_end = link[ENTRY_COUNT].tok;
  assign out_free = !out_valid_q || !out_stall_i;
  // freeze the row when a new hit needs the held result pushed out and the output is not free
  assign adv      = !(hit_any && pend_valid_q && !out_free);

  assign push_scan  = adv && hit_any && pend_valid_q;
  assign push_flush = (state_q == catm_pkg::StFlush) && pend_valid_q && out_free;

  always_comb begin
    state_d      = state_q;
    pend_valid_d = pend_valid_q;
    case (state_q)
      catm_pkg::StIdle: begin
        if (tick_xfer) begin
          state_d = catm_pkg::StScan;
        end
      end
      catm_pkg::StScan: begin
        if (adv && hit_any) begin
          pend_valid_d = 1'b1;
        end
        if (adv && scan_end) begin
          state_d = catm_pkg::StFlush;
        end
      end
      catm_pkg::StFlush: begin
        if (!pend_valid_q || out_free) begin
          state_d      = catm_pkg::StIdle;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        state_d = catm_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_d = push_scan || push_flush || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= catm_pkg::StIdle;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      tick_q <= '{minute:       minute_i,
                  hour:         hour_i,
                  weekday:      weekday_i,
                  day:          day_of_month_i,
                  month:        month_number_i,
                  month_length: month_length_i};
    end
    if (adv && hit_any) begin
      pend_idx_q <= hit_idx;
      pend_tag_q <= hit_tag;
    end
    if (push_scan || push_flush) begin
      out_idx_q  <= pend_idx_q;
      out_tag_q  <= pend_tag_q;
      out_last_q <= push_flush;
    end
  end

  assign in_stall_o    = (state_q != catm_pkg::StIdle);
  assign out_valid_o   = out_valid_q;
  assign fired_index_o = out_idx_q;
  assign fired_tag_o   = out_tag_q;
  assign last_fired_o  = out_last_q;

endmodule

// File: rtl/catm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catm_checker
// port-level checks for the calendar alarm matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "calendar_alarm_table_matcher_top_defines.svh"

module catm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       kind_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] fired_index_o,
  input logic [7:0] fired_tag_o,
  input logic       last_fired_o
);

  `CATM_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)
  `CATM_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i,
    $stable(fired_index_o) && $stable(fired_tag_o) && $stable(last_fired_o))
  // a write transfer finishes at once
  `CATM_ASSERT_NEXT(a_write_no_busy, in_valid_i && !in_stall_o && kind_i, !in_stall_o)
  // a tick transfer always starts a scan
  `CATM_ASSERT_NEXT(a_tick_busy, in_valid_i && !in_stall_o && !kind_i, in_stall_o)
  // results only come out of a scan
  `CATM_ASSERT_NOW(a_result_from_scan, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind calendar_alarm_table_matcher_top catm_checker u_catm_checker (.*);

// File: dv/tb_calendar_alarm_table_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_alarm_table_matcher_top
// drives writes and minute ticks into the alarm table matcher with random
// gaps on both channels and checks every firing against a predicted table
// ----------------------------------------------------------------------------
module tb_calendar_alarm_table_matcher_top;

  localparam int unsigned Entries       = catm_pkg::EntryCountDef;
  localparam int unsigned MaxFires      = catm_pkg::MaxFires;
  localparam logic [5:0]  MinuteWild    = catm_pkg::MinuteWild;
  localparam logic [4:0]  HourWild      = catm_pkg::HourWild;
  localparam logic [2:0]  WeekdayWild   = catm_pkg::WeekdayWild;
  localparam logic [4:0]  DayWild       = catm_pkg::DayWild;
  localparam logic [3:0]  MonthWild     = catm_pkg::MonthWild;
  localparam logic [7:0]  RepeatForever = catm_pkg::RepeatForever;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned DrainCycles   = 4 * (Entries + 2);
  localparam int unsigned RandomItems   = 430;
  localparam int unsigned MismatchShown = 10;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned WindowHalf    = 3;
  localparam int unsigned WindowSpan    = 6;
  localparam bit          KindTick      = 1'b0;
  localparam bit          KindWrite     = 1'b1;

  typedef catm_pkg::pattern_t pattern_t;

  typedef struct packed {
    bit       kind;
    bit [2:0] entry_index;
    bit [5:0] minute;
    bit [4:0] hour;
    bit [2:0] weekday;
    bit [4:0] day_of_month;
    bit [3:0] month_number;
    bit [4:0] month_length;
    bit       entry_enable;
    bit [7:0] repeat_count;
    bit [7:0] entry_tag;
  } alarm_item_t;

  typedef struct packed {
    bit [2:0] idx;
    bit [7:0] tag;
    bit       last;
  } alarm_fire_t;

  // predicted alarm table and the firings still owed by the block
  class alarm_fire_tracker;
    pattern_t    table_pat [Entries];
    bit [7:0]    repeats   [Entries];
    bit          armed     [Entries];
    alarm_fire_t pending   [$];
    int unsigned mismatches;

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      mismatches = 0;
    endfunction

    function bit date_hits(pattern_t p, alarm_item_t t);
      int unsigned last, d, lo, hi;
      if (p.minute < MinuteWild && p.minute != t.minute) return 1'b0;
      if (p.hour < HourWild && p.hour != t.hour) return 1'b0;
      if (p.weekday < WeekdayWild && p.weekday != t.weekday) return 1'b0;
      if (p.day < DayWild) begin
        last = (t.month_length == 0) ? 0 : t.month_length - 1;
        d = (p.day < last) ? p.day : last;
        if (p.weekday < WeekdayWild) begin
          // weekday given too: any day in a week around the pattern day
          if (d <= WindowHalf) begin
            lo = 0;
            hi = WindowSpan;
          end else if (d + WindowHalf >= last) begin
            lo = (last >= WindowSpan) ? last - WindowSpan : 0;
            hi = last;
          end else begin
            lo = d - WindowHalf;
            hi = d + WindowHalf;
          end
          if (t.day_of_month < lo || t.day_of_month > hi) return 1'b0;
        end else if (d != t.day_of_month) begin
          return 1'b0;
        end
      end
      if (p.month < MonthWild && p.month != t.month_number) return 1'b0;
      return 1'b1;
    endfunction

    function void absorb_item(alarm_item_t it);
      int unsigned n;
      n = 0;
      if (it.kind == KindWrite) begin
        if (it.entry_index < Entries) begin
          table_pat[it.entry_index] = '{minute: it.minute, hour: it.hour,
                                        weekday: it.weekday, day: it.day_of_month,
                                        month: it.month_number, tag: it.entry_tag};
          repeats[it.entry_index] = it.repeat_count;
          armed[it.entry_index] = it.entry_enable;
        end
        return;
      end
      for (int i = 0; i < Entries && n < MaxFires; i++) begin
        if (!armed[i] || !date_hits(table_pat[i], it)) continue;
        pending.push_back('{idx: 3'(i), tag: table_pat[i].tag, last: 1'b0});
        n++;
        if (repeats[i] == 0) begin
          armed[i] = 1'b0;
        end else if (repeats[i] != RepeatForever) begin
          repeats[i] = 8'(repeats[i] - 8'd1);
        end
      end
      if (n > 0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void match_fire(logic [2:0] idx, logic [7:0] tag, logic last);
      alarm_fire_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MismatchShown)
          $display("unexpected firing: index %0d tag %0h last %0b", idx, tag, last);
        return;
      end
      want = pending.pop_front();
      if (want.idx !== idx || want.tag !== tag || want.last !== last) begin
        mismatches++;
        if (mismatches <= MismatchShown)
          $display({"firing mismatch: expected index %0d tag %0h last %0b, ",
                    "got index %0d tag %0h last %0b"},
                   want.idx, want.tag, want.last, idx, tag, last);
      end
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic       kind_i         = 1'b0;
  logic [2:0] entry_index_i  = '0;
  logic [5:0] minute_i       = '0;
  logic [4:0] hour_i         = '0;
  logic [2:0] weekday_i      = '0;
  logic [4:0] day_of_month_i = '0;
  logic [3:0] month_number_i = '0;
  logic [4:0] month_length_i = '0;
  logic       entry_enable_i = 1'b0;
  logic [7:0] repeat_count_i = '0;
  logic [7:0] entry_tag_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [2:0] fired_index_o;
  logic [7:0] fired_tag_o;
  logic       last_fired_o;

  alarm_fire_tracker board = new();

  // stimulus-side copy of what was written, used to aim ticks at entries
  alarm_item_t loaded_pat [Entries];
  bit          loaded     [Entries];
  bit          steady      = 1'b0;
  int unsigned hold_cycles = 0;

  calendar_alarm_table_matcher_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic alarm_item_t make_write(int idx, int mi, int hr, int wd, int dy,
                                             int mo, int en, int rep, int tag);
    alarm_item_t it;
    it = '0;
    it.kind         = KindWrite;
    it.entry_index  = 3'(idx);
    it.minute       = 6'(mi);
    it.hour         = 5'(hr);
    it.weekday      = 3'(wd);
    it.day_of_month = 5'(dy);
    it.month_number = 4'(mo);
    it.entry_enable = 1'(en);
    it.repeat_count = 8'(rep);
    it.entry_tag    = 8'(tag);
    return it;
  endfunction

  function automatic alarm_item_t make_tick(int mi, int hr, int wd, int dy, int mo, int mlen);
    alarm_item_t it;
    it = '0;
    it.kind         = KindTick;
    it.minute       = 6'(mi);
    it.hour         = 5'(hr);
    it.weekday      = 3'(wd);
    it.day_of_month = 5'(dy);
    it.month_number = 4'(mo);
    it.month_length = 5'(mlen);
    return it;
  endfunction

  task automatic send_item(alarm_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i         <= it.kind;
    entry_index_i  <= it.entry_index;
    minute_i       <= it.minute;
    hour_i         <= it.hour;
    weekday_i      <= it.weekday;
    day_of_month_i <= it.day_of_month;
    month_number_i <= it.month_number;
    month_length_i <= it.month_length;
    entry_enable_i <= it.entry_enable;
    repeat_count_i <= it.repeat_count;
    entry_tag_i    <= it.entry_tag;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.absorb_item(it);
    if (it.kind == KindWrite && it.entry_index < Entries) begin
      loaded_pat[it.entry_index] = it;
      loaded[it.entry_index] = 1'b1;
    end
  endtask

  // result side: random stall before each transfer, one long hold-off on request
  initial begin
    int unsigned wait_n;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_n = steady ? 0 : $urandom_range(0, 6);
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.match_fire(fired_index_o, fired_tag_o, last_fired_o);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    alarm_item_t it;
    alarm_item_t p;
    int unsigned roll;
    int unsigned last;
    int          dd;

    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    send_item(make_tick(0, 0, 0, 0, 0, 31));  // empty table, nothing fires
    send_item(make_write(0, 63, 31, WeekdayWild, DayWild, 15, 1, RepeatForever, 8'hff));
    send_item(make_write(7, 0, 0, WeekdayWild, 0, 0, 1, 0, 8'h00));
    send_item(make_tick(0, 0, 0, 0, 0, 31));  // entry 7 fires once and retires
    send_item(make_tick(0, 0, 0, 0, 0, 31));
    // window near month start
    send_item(make_write(1, MinuteWild, HourWild, 3, 2, MonthWild, 1, 1, 8'h11));
    send_item(make_tick(59, 23, 3, 6, 11, 30));
    send_item(make_tick(59, 23, 3, 7, 11, 30));
    // pattern day past month end, window near month end
    send_item(make_write(2, MinuteWild, HourWild, 5, 30, 1, 1, 2, 8'h22));
    send_item(make_tick(5, 10, 5, 21, 1, 28));
    send_item(make_tick(5, 10, 5, 20, 1, 28));
    // day only, clamped to the last day
    send_item(make_write(3, MinuteWild, HourWild, WeekdayWild, 30, MonthWild, 1, 3, 8'h33));
    send_item(make_tick(1, 2, 0, 27, 4, 28));
    // zero month length
    send_item(make_write(4, MinuteWild, HourWild, WeekdayWild, 5, MonthWild, 1, 0, 8'h44));
    send_item(make_tick(1, 2, 0, 0, 4, 0));
    // short month saturates the window low bound
    send_item(make_write(5, MinuteWild, HourWild, 2, 4, MonthWild, 1, 5, 8'h55));
    send_item(make_tick(0, 0, 2, 0, 0, 5));
    send_item(make_write(0, 63, 31, WeekdayWild, DayWild, 15, 0, 0, 8'h00));
    // every entry wildcard: a full tick of firings
    for (int i = 0; i < Entries; i++)
      send_item(make_write(i, 60 + i % 4, 24 + i, WeekdayWild, DayWild, 12 + i % 4, 1, i,
                           8'h80 + i));
    send_item(make_tick(63, 31, 7, 31, 15, 31));

    // random part
    for (int k = 0; k < RandomItems; k++) begin
      steady = (k >= 200 && k < 260);
      if (k == 100) hold_cycles = HoldOffCycles;
      if (k == 320) begin
        in_valid_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      it = '0;
      it.entry_index  = 3'($urandom);
      it.entry_enable = 1'($urandom);
      it.repeat_count = 8'($urandom);
      it.entry_tag    = 8'($urandom);
      it.month_length = 5'($urandom);
      if (roll < 30) begin
        it.kind = KindWrite;
        it.minute = ($urandom_range(0, 99) < 40) ? 6'($urandom_range(60, 63))
                                                 : 6'($urandom_range(0, 59));
        it.hour = ($urandom_range(0, 99) < 40) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
        it.weekday = ($urandom_range(0, 99) < 45) ? WeekdayWild : 3'($urandom_range(0, 6));
        it.day_of_month = ($urandom_range(0, 99) < 40) ? DayWild : 5'($urandom_range(0, 30));
        it.month_number = ($urandom_range(0, 99) < 40) ? 4'($urandom_range(12, 15))
                                                       : 4'($urandom_range(0, 11));
        it.entry_enable = ($urandom_range(0, 99) < 85);
        case ($urandom_range(0, 3))
          0: it.repeat_count = RepeatForever;
          1: it.repeat_count = 8'($urandom_range(0, 3));
          default: it.repeat_count = 8'($urandom);
        endcase
      end else if (roll < 85 && loaded[it.entry_index]) begin
        // tick aimed at a loaded entry, wildcards filled at random
        it.kind = KindTick;
        p = loaded_pat[it.entry_index];
        it.month_length = ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                      : 5'($urandom_range(28, 31));
        it.minute = (p.minute < MinuteWild) ? p.minute : 6'($urandom_range(0, 59));
        it.hour = (p.hour < HourWild) ? p.hour : 5'($urandom_range(0, 23));
        it.weekday = (p.weekday < WeekdayWild) ? p.weekday : 3'($urandom_range(0, 6));
        it.month_number = (p.month_number < MonthWild) ? p.month_number
                                                       : 4'($urandom_range(0, 11));
        last = (it.month_length == 0) ? 0 : it.month_length - 1;
        if (p.day_of_month >= DayWild) begin
          it.day_of_month = 5'($urandom_range(0, 30));
        end else if (p.weekday < WeekdayWild) begin
          dd = int'(p.day_of_month) + int'($urandom_range(0, 8)) - 4;
          if (dd < 0) dd = 0;
          if (dd > 31) dd = 31;
          it.day_of_month = 5'(dd);
        end else begin
          it.day_of_month = (p.day_of_month < last) ? p.day_of_month : 5'(last);
        end
        // now and then replace one field with a random value, which may make the entry miss
        case ($urandom_range(0, 11))
          0: it.minute = 6'($urandom);
          1: it.hour = 5'($urandom);
          2: it.weekday = 3'($urandom);
          3: it.month_number = 4'($urandom);
          default: ;
        endcase
      end else begin
        it.kind = KindTick;
        it.minute       = 6'($urandom);
        it.hour         = 5'($urandom);
        it.weekday      = 3'($urandom);
        it.day_of_month = 5'($urandom);
        it.month_number = 4'($urandom);
      end
      send_item(it);
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: calendar_alarm_table_matcher_top.f
+incdir+rtl
rtl/catm_pkg.sv
rtl/catm_cell.sv
rtl/calendar_alarm_table_matcher_top.sv
rtl/catm_checker.sv
dv/tb_calendar_alarm_table_matcher_top.sv
